[rtl/srs_pkg.sv]
// Shared types, codes and request/response tables for the settings request sequencer.
// Used by srs_step and settings_request_sequencer_core; no dependencies.
`default_nettype none

package srs_pkg;

  // Input item modes
  localparam logic [1:0] MODE_TRIGGER = 2'd0;
  localparam logic [1:0] MODE_RX      = 2'd1;
  localparam logic [1:0] MODE_POLL    = 2'd2;
  localparam logic [1:0] MODE_TICK    = 2'd3;

  // Sequence kinds
  localparam logic [1:0] KIND_INIT     = 2'd0;
  localparam logic [1:0] KIND_RETRIEVE = 2'd1;
  localparam logic [1:0] KIND_UPDATE   = 2'd2;
  localparam logic [1:0] KIND_RESET    = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CHANNEL = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Phases
  localparam logic [4:0] P_IDLE   = 5'd0;
  localparam logic [4:0] P_ENTER  = 5'd1;
  localparam logic [4:0] P_EXIT   = 5'd2;
  localparam logic [4:0] P_INIT00 = 5'd3;
  localparam logic [4:0] P_INIT60 = 5'd6;
  localparam logic [4:0] P_SET0   = 5'd7;
  localparam logic [4:0] P_SETN   = 5'd15;
  localparam logic [4:0] P_R10    = 5'd16;
  localparam logic [4:0] P_R2X    = 5'd17;
  localparam logic [4:0] P_RF05   = 5'd18;
  localparam logic [4:0] P_RESET  = 5'd19;
  localparam logic [4:0] NPHASES  = 5'd20;

  localparam logic [3:0] LAST_ITEM = 4'd8;
  localparam logic [3:0] FULL_LEN  = 4'd8;

  localparam logic [10:0] ID_E = 11'h71E;
  localparam logic [10:0] ID_F = 11'h71F;
  localparam logic [10:0] RSP_ID_E = 11'h72E;
  localparam logic [10:0] RSP_ID_F = 11'h72F;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [4:0]  phase;
    logic        request_sent;
    logic        second_frame_seen;
    logic [15:0] elapsed_ms;
    logic [1:0]  active_kind;
    logic [4:0]  update_phase;
    logic [7:0]  update_value;
  } srs_state_t;

  typedef struct packed {
    logic        accepted;
    logic        send_valid;
    logic [10:0] send_id;
    logic [7:0]  send_byte0;
    logic [7:0]  send_byte1;
    logic [7:0]  send_byte2;
    logic [7:0]  send_byte3;
    logic        idle;
    logic [4:0]  phase_out;
  } srs_result_t;

  // Request bytes 0..2 for each phase
  function automatic logic [23:0] req_bytes(input logic [4:0] p);
    logic [23:0] r;
    unique case (p)
      5'd1:    r = 24'h0210C0;
      5'd2:    r = 24'h021081;
      5'd3:    r = 24'h023B00;
      5'd4:    r = 24'h023B20;
      5'd5:    r = 24'h023B40;
      5'd6:    r = 24'h023B60;
      5'd7:    r = 24'h033B10;
      5'd8:    r = 24'h033B37;
      5'd9:    r = 24'h033B39;
      5'd10:   r = 24'h033B47;
      5'd11:   r = 24'h033B2A;
      5'd12:   r = 24'h033B2E;
      5'd13:   r = 24'h033B2F;
      5'd14:   r = 24'h033B02;
      5'd15:   r = 24'h033B01;
      5'd16:   r = 24'h022101;
      5'd17:   r = 24'h30000A;
      5'd18:   r = 24'h022101;
      5'd19:   r = 24'h033B1F;
      default: r = 24'h000000;
    endcase
    return r;
  endfunction

  // Expected reply bytes 0..2 for each phase
  function automatic logic [23:0] rsp_bytes(input logic [4:0] p);
    logic [23:0] r;
    unique case (p)
      5'd1:    r = 24'h0250C0;
      5'd2:    r = 24'h025081;
      5'd3:    r = 24'h067B00;
      5'd4:    r = 24'h067B20;
      5'd5:    r = 24'h067B40;
      5'd6:    r = 24'h067B60;
      5'd7:    r = 24'h027B10;
      5'd8:    r = 24'h027B37;
      5'd9:    r = 24'h027B39;
      5'd10:   r = 24'h027B47;
      5'd11:   r = 24'h027B2A;
      5'd12:   r = 24'h027B2E;
      5'd13:   r = 24'h027B2F;
      5'd14:   r = 24'h027B02;
      5'd15:   r = 24'h027B01;
      5'd16:   r = 24'h100000;
      5'd17:   r = 24'h210000;
      5'd18:   r = 24'h050000;
      5'd19:   r = 24'h027B1F;
      default: r = 24'h000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/settings_request_sequencer_core.sv]
// Top level of the settings request sequencer: state and config registers, result register.
// Depends on srs_pkg and srs_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per beat: a trigger, a received
//   frame, a poll for the outgoing request, or a one-millisecond tick.
//   Output channel (out_valid/out_ready) returns exactly one result beat per input beat:
//   accepted flag, request frame (send_valid, send_id, send_byte0..3), idle, phase_out.
//   Config channel (cfg_valid/cfg_ready) writes channel_select (index 0) or timeout_ms
//   (index 1); cfg_ready is always high. Write it only while the block is quiet.
// Timing:
//   The result of a beat is registered at the edge that takes it and is shown right after that edge.
//   Throughput is one item per cycle while out_ready is high; the sequencer state is updated
//   in the same edge the item is taken, so the next item sees it immediately.
//   While a result waits and out_ready is low, in_ready is low; in_ready returns as soon
//   as the waiting result is taken (or in the same cycle it is taken).
// Reset:
//   Synchronous rst returns to idle with elapsed count zero, channel 0x71E rules,
//   timeout 500 ms, update value 0xFF, and no result pending.
`default_nettype none

module settings_request_sequencer_core
  import srs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [1:0]  seq_kind,
  input  logic [3:0]  update_item,
  input  logic [7:0]  set_value,
  input  logic [10:0] rx_id,
  input  logic [3:0]  rx_length,
  input  logic [7:0]  rx_byte0,
  input  logic [7:0]  rx_byte1,
  input  logic [7:0]  rx_byte2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic        send_valid,
  output logic [10:0] send_id,
  output logic [7:0]  send_byte0,
  output logic [7:0]  send_byte1,
  output logic [7:0]  send_byte2,
  output logic [7:0]  send_byte3,
  output logic        idle,
  output logic [4:0]  phase_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  srs_state_t  state;
  srs_state_t  state_next;
  srs_result_t result;
  srs_result_t result_next;
  logic        channel_select;
  logic [15:0] timeout_ms;
  logic        take;

  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  srs_step u_step (
    .cur            (state),
    .channel_select (channel_select),
    .timeout_ms     (timeout_ms),
    .mode           (mode),
    .seq_kind       (seq_kind),
    .update_item    (update_item),
    .set_value      (set_value),
    .rx_id          (rx_id),
    .rx_length      (rx_length),
    .rx_byte0       (rx_byte0),
    .rx_byte1       (rx_byte1),
    .rx_byte2       (rx_byte2),
    .nxt            (state_next),
    .res            (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= P_IDLE;
      state.request_sent      <= 1'b0;
      state.second_frame_seen <= 1'b0;
      state.elapsed_ms        <= '0;
      state.active_kind       <= KIND_INIT;
      state.update_phase      <= '0;
      state.update_value      <= 8'hFF;
    end else if (take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= 1'b0;
      timeout_ms     <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHANNEL: channel_select <= cfg_data[0];
        CFG_TIMEOUT: timeout_ms     <= cfg_data;
      endcase
    end
  end

  // Result register: load on each taken beat, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign accepted   = result.accepted;
  assign send_valid = result.send_valid;
  assign send_id    = result.send_id;
  assign send_byte0 = result.send_byte0;
  assign send_byte1 = result.send_byte1;
  assign send_byte2 = result.send_byte2;
  assign send_byte3 = result.send_byte3;
  assign idle       = result.idle;
  assign phase_out  = result.phase_out;

endmodule

`default_nettype wire

[rtl/srs_step.sv]
// Single-pass step logic: next sequencer state and the result beat for one input item.
// Depends on srs_pkg (state/result structs, phase codes, request and reply tables).
`default_nettype none

module srs_step
  import srs_pkg::*;
(
  input  srs_state_t  cur,
  input  logic        channel_select,
  input  logic [15:0] timeout_ms,
  input  logic [1:0]  mode,
  input  logic [1:0]  seq_kind,
  input  logic [3:0]  update_item,
  input  logic [7:0]  set_value,
  input  logic [10:0] rx_id,
  input  logic [3:0]  rx_length,
  input  logic [7:0]  rx_byte0,
  input  logic [7:0]  rx_byte1,
  input  logic [7:0]  rx_byte2,
  output srs_state_t  nxt,
  output srs_result_t res
);

  logic        main_ch;
  logic [23:0] rsp;
  logic [23:0] req;
  logic        match;
  logic [4:0]  first;
  logic [4:0]  np;
  logic        sfs_np;
  logic [3:0]  item_sat;

  assign main_ch = !channel_select;
  assign rsp     = rsp_bytes(cur.phase);
  assign req     = req_bytes(cur.phase);
  assign item_sat = (update_item > LAST_ITEM) ? LAST_ITEM : update_item;

  // Does the received payload match the reply expected in this phase
  always_comb begin
    if (cur.phase == P_IDLE || cur.phase >= NPHASES) begin
      match = 1'b0;
    end else if (cur.phase == P_R2X) begin
      match = (rx_byte0 == 8'h21) || (rx_byte0 == 8'h22);
    end else if (cur.phase == P_R10 || cur.phase == P_RF05) begin
      match = (rx_byte0 == rsp[23:16]);
    end else begin
      match = (rx_byte0 == rsp[23:16]) && (rx_byte1 == rsp[15:8]) && (rx_byte2 == rsp[7:0]);
    end
  end

  // Phase after a matched reply
  always_comb begin
    sfs_np = cur.second_frame_seen;
    np     = P_IDLE;
    if (cur.active_kind == KIND_RETRIEVE) begin
      first = main_ch ? P_R10 : P_RF05;
    end else if (cur.active_kind == KIND_UPDATE) begin
      first = cur.update_phase;
    end else begin
      first = P_RESET;
    end
    if (cur.active_kind == KIND_INIT) begin
      if (cur.phase == P_ENTER) begin
        np = P_INIT00;
      end else if (main_ch && cur.phase >= P_INIT00 && cur.phase < P_INIT60) begin
        np = cur.phase + 5'd1;
      end else if ((main_ch && cur.phase == P_INIT60) || (!main_ch && cur.phase == P_INIT00)) begin
        np = P_EXIT;
      end
    end else if (cur.phase == P_ENTER) begin
      np = first;
    end else if (cur.active_kind != KIND_RETRIEVE && cur.phase == first) begin
      np = main_ch ? P_R10 : P_RF05;
    end else if (main_ch) begin
      if (cur.phase == P_R10) begin
        sfs_np = 1'b0;
        np     = P_R2X;
      end else if (cur.phase == P_R2X) begin
        // first of the two consecutive frames: hold the phase, remember it; the second exits
        if (cur.second_frame_seen) begin
          np = P_EXIT;
        end else begin
          sfs_np = 1'b1;
          np     = P_R2X;
        end
      end
    end else if (cur.phase == P_RF05) begin
      np = P_EXIT;
    end
  end

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (mode)
      MODE_TRIGGER: begin
        if (cur.phase == P_IDLE) begin
          nxt.active_kind = seq_kind;
          if (seq_kind == KIND_UPDATE) begin
            nxt.update_phase = P_SET0 + {1'b0, item_sat};
            nxt.update_value = set_value;
          end
          nxt.elapsed_ms   = '0;
          nxt.phase        = P_ENTER;
          nxt.request_sent = 1'b0;
          res.accepted     = 1'b1;
        end
      end
      MODE_RX: begin
        if (rx_length >= FULL_LEN && rx_id == (channel_select ? RSP_ID_F : RSP_ID_E) && match)
        begin
          res.accepted          = 1'b1;
          nxt.second_frame_seen = sfs_np;
          if (np != cur.phase) begin
            nxt.phase        = np;
            nxt.request_sent = 1'b0;
          end
        end
      end
      MODE_POLL: begin
        if (cur.elapsed_ms >= timeout_ms) begin
          nxt.phase = P_IDLE;
        end else if (cur.phase != P_IDLE && !cur.request_sent && cur.phase < NPHASES) begin
          nxt.request_sent = 1'b1;
          res.send_valid   = 1'b1;
          res.send_id      = channel_select ? ID_F : ID_E;
          res.send_byte0   = req[23:16];
          res.send_byte1   = req[15:8];
          res.send_byte2   = req[7:0];
          if (cur.phase >= P_SET0 && cur.phase <= P_SETN) begin
            res.send_byte3 = cur.update_value;
          end else if (cur.phase == P_RESET) begin
            res.send_byte3 = 8'h00;
          end else begin
            res.send_byte3 = 8'hFF;
          end
        end
      end
      MODE_TICK: begin
        if (cur.elapsed_ms != ELAPSED_MAX) begin
          nxt.elapsed_ms = cur.elapsed_ms + 16'd1;
        end
      end
    endcase
    res.idle      = (nxt.phase == P_IDLE);
    res.phase_out = nxt.phase;
  end

endmodule

`default_nettype wire

[sim/tb_settings_request_sequencer_core.sv]
// Testbench for settings_request_sequencer_core: a scripted run of sequences, then random
// traffic under several channel and timeout settings, checked against an in-bench sequencer.
// Depends on srs_pkg and the RTL under rtl/.
`default_nettype none

module tb_settings_request_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PER_SETTING = 120;
  localparam logic [7:0] CONSEC_A = 8'h21;
  localparam logic [7:0] CONSEC_B = 8'h22;

  // Request and expected reply bytes 0..2, indexed by phase
  localparam logic [23:0] REQ_TAB [0:19] = '{
    24'h000000, 24'h0210C0, 24'h021081, 24'h023B00, 24'h023B20,
    24'h023B40, 24'h023B60, 24'h033B10, 24'h033B37, 24'h033B39,
    24'h033B47, 24'h033B2A, 24'h033B2E, 24'h033B2F, 24'h033B02,
    24'h033B01, 24'h022101, 24'h30000A, 24'h022101, 24'h033B1F
  };
  localparam logic [23:0] RSP_TAB [0:19] = '{
    24'h000000, 24'h0250C0, 24'h025081, 24'h067B00, 24'h067B20,
    24'h067B40, 24'h067B60, 24'h027B10, 24'h027B37, 24'h027B39,
    24'h027B47, 24'h027B2A, 24'h027B2E, 24'h027B2F, 24'h027B02,
    24'h027B01, 24'h100000, 24'h210000, 24'h050000, 24'h027B1F
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  kind;
    logic [3:0]  item;
    logic [7:0]  value;
    logic [10:0] rid;
    logic [3:0]  rlen;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
  } seq_event_t;

  typedef struct packed {
    seq_event_t  ev;
    logic        typed;
    srs_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [1:0]  seq_kind = '0;
  logic [3:0]  update_item = '0;
  logic [7:0]  set_value = '0;
  logic [10:0] rx_id = '0;
  logic [3:0]  rx_length = '0;
  logic [7:0]  rx_byte0 = '0;
  logic [7:0]  rx_byte1 = '0;
  logic [7:0]  rx_byte2 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic        send_valid;
  logic [10:0] send_id;
  logic [7:0]  send_byte0;
  logic [7:0]  send_byte1;
  logic [7:0]  send_byte2;
  logic [7:0]  send_byte3;
  logic        idle;
  logic [4:0]  phase_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // In-bench copy of the sequencer and its registers
  srs_state_t  seq_st;
  logic        cfg_chan;
  logic [15:0] cfg_tmo;

  srs_result_t pending_results [$];
  script_row_t script [$];
  int          fail_count = 0;
  int          send_idle_pct = 20;
  int          recv_idle_pct = 82;

  settings_request_sequencer_core DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic reply_ok(input logic [4:0] p, input logic [7:0] b0, b1, b2);
    logic [23:0] want;
    if (p == P_IDLE || p >= NPHASES) return 1'b0;
    want = RSP_TAB[p];
    if (p == P_R2X) return b0 == CONSEC_A || b0 == CONSEC_B;
    if (p == P_R10 || p == P_RF05) return b0 == want[23:16];
    return {b0, b1, b2} == want;
  endfunction

  // Phase after a matched reply; may note the first of the two consecutive frames
  function automatic logic [4:0] advance_phase(input logic [4:0] p);
    logic       main_ch;
    logic [4:0] first;
    main_ch = (cfg_chan == 1'b0);
    if (seq_st.active_kind == KIND_INIT) begin
      if (p == P_ENTER) return P_INIT00;
      if (main_ch && p >= P_INIT00 && p < P_INIT60) return p + 5'd1;
      if ((main_ch && p == P_INIT60) || (!main_ch && p == P_INIT00)) return P_EXIT;
      return P_IDLE;
    end
    case (seq_st.active_kind)
      KIND_RETRIEVE: first = main_ch ? P_R10 : P_RF05;
      KIND_UPDATE:   first = seq_st.update_phase;
      default:       first = P_RESET;
    endcase
    if (p == P_ENTER) return first;
    if (seq_st.active_kind != KIND_RETRIEVE && p == first) return main_ch ? P_R10 : P_RF05;
    if (main_ch && p == P_R10) begin
      seq_st.second_frame_seen = 1'b0;
      return P_R2X;
    end
    if (main_ch && p == P_R2X) begin
      if (seq_st.second_frame_seen) return P_EXIT;
      seq_st.second_frame_seen = 1'b1;
      return P_R2X;
    end
    if (!main_ch && p == P_RF05) return P_EXIT;
    return P_IDLE;
  endfunction

  function automatic srs_result_t seq_step(input seq_event_t ev);
    srs_result_t r;
    logic [4:0]  np;
    logic [23:0] req;
    r = '0;
    case (ev.mode)
      MODE_TRIGGER: begin
        if (seq_st.phase == P_IDLE) begin
          seq_st.active_kind = ev.kind;
          if (ev.kind == KIND_UPDATE) begin
            seq_st.update_phase =
              P_SET0 + {1'b0, ((ev.item > LAST_ITEM) ? LAST_ITEM : ev.item)};
            seq_st.update_value = ev.value;
          end
          seq_st.elapsed_ms = '0;
          seq_st.phase = P_ENTER;
          seq_st.request_sent = 1'b0;
          r.accepted = 1'b1;
        end
      end
      MODE_RX: begin
        if (ev.rlen >= FULL_LEN && ev.rid == (cfg_chan ? RSP_ID_F : RSP_ID_E) &&
            reply_ok(seq_st.phase, ev.b0, ev.b1, ev.b2)) begin
          np = advance_phase(seq_st.phase);
          r.accepted = 1'b1;
          if (np != seq_st.phase) begin
            seq_st.phase = np;
            seq_st.request_sent = 1'b0;
          end
        end
      end
      MODE_POLL: begin
        if (seq_st.elapsed_ms >= cfg_tmo) begin
          seq_st.phase = P_IDLE;
        end else if (seq_st.phase != P_IDLE && !seq_st.request_sent &&
                     seq_st.phase < NPHASES) begin
          seq_st.request_sent = 1'b1;
          req = REQ_TAB[seq_st.phase];
          r.send_valid = 1'b1;
          r.send_id = cfg_chan ? ID_F : ID_E;
          {r.send_byte0, r.send_byte1, r.send_byte2} = req;
          if (seq_st.phase >= P_SET0 && seq_st.phase <= P_SETN)
            r.send_byte3 = seq_st.update_value;
          else if (seq_st.phase == P_RESET)
            r.send_byte3 = 8'h00;
          else
            r.send_byte3 = 8'hFF;
        end
      end
      MODE_TICK: begin
        if (seq_st.elapsed_ms != ELAPSED_MAX) seq_st.elapsed_ms = seq_st.elapsed_ms + 16'd1;
      end
    endcase
    r.idle = (seq_st.phase == P_IDLE);
    r.phase_out = seq_st.phase;
    return r;
  endfunction

  function automatic seq_event_t rand_event();
    seq_event_t  ev;
    int unsigned bits;
    bits = $urandom;
    ev.mode = bits[1:0];
    ev.kind = bits[3:2];
    ev.item = bits[7:4];
    ev.value = bits[15:8];
    ev.rlen = bits[19:16];
    ev.rid = bits[30:20];
    bits = $urandom;
    ev.b0 = bits[7:0];
    ev.b1 = bits[15:8];
    ev.b2 = bits[23:16];
    return ev;
  endfunction

  function automatic seq_event_t mk_trigger(input int unsigned kind, item, value);
    seq_event_t ev;
    ev = rand_event();
    ev.mode = MODE_TRIGGER;
    ev.kind = kind[1:0];
    ev.item = item[3:0];
    ev.value = value[7:0];
    return ev;
  endfunction

  function automatic seq_event_t mk_frame(input int unsigned id, len, b0, b1, b2);
    seq_event_t ev;
    ev = rand_event();
    ev.mode = MODE_RX;
    ev.rid = id[10:0];
    ev.rlen = len[3:0];
    ev.b0 = b0[7:0];
    ev.b1 = b1[7:0];
    ev.b2 = b2[7:0];
    return ev;
  endfunction

  function automatic seq_event_t mk_poll();
    seq_event_t ev;
    ev = rand_event();
    ev.mode = MODE_POLL;
    return ev;
  endfunction

  function automatic seq_event_t mk_tick();
    seq_event_t ev;
    ev = rand_event();
    ev.mode = MODE_TICK;
    return ev;
  endfunction

  // Frame that the current phase waits for, with random don't-care bytes
  function automatic seq_event_t good_reply();
    seq_event_t  ev;
    logic [23:0] rb;
    ev = mk_frame(32'(cfg_chan ? RSP_ID_F : RSP_ID_E), $urandom_range(15, 8), $urandom,
                  $urandom, $urandom);
    if (seq_st.phase != P_IDLE && seq_st.phase < NPHASES) begin
      rb = RSP_TAB[seq_st.phase];
      if (seq_st.phase == P_R2X)
        ev.b0 = $urandom_range(1) ? CONSEC_B : CONSEC_A;
      else if (seq_st.phase == P_R10 || seq_st.phase == P_RF05)
        ev.b0 = rb[23:16];
      else
        {ev.b0, ev.b1, ev.b2} = rb;
    end
    return ev;
  endfunction

  function automatic srs_result_t pinned(input int unsigned acc, sv, id, b0, b1, b2, b3, ph);
    srs_result_t r;
    r.accepted = acc[0];
    r.send_valid = sv[0];
    r.send_id = id[10:0];
    r.send_byte0 = b0[7:0];
    r.send_byte1 = b1[7:0];
    r.send_byte2 = b2[7:0];
    r.send_byte3 = b3[7:0];
    r.phase_out = ph[4:0];
    r.idle = (ph[4:0] == P_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    srs_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("send_valid", 32'(want.send_valid), 32'(send_valid));
        check_field("send_id", 32'(want.send_id), 32'(send_id));
        check_field("send_byte0", 32'(want.send_byte0), 32'(send_byte0));
        check_field("send_byte1", 32'(want.send_byte1), 32'(send_byte1));
        check_field("send_byte2", 32'(want.send_byte2), 32'(send_byte2));
        check_field("send_byte3", 32'(want.send_byte3), 32'(send_byte3));
        check_field("idle", 32'(want.idle), 32'(idle));
        check_field("phase_out", 32'(want.phase_out), 32'(phase_out));
      end
    end
  end

  // Offer one beat, hold it until taken, then record what it must produce
  task automatic push_event(input seq_event_t ev, input logic typed, input srs_result_t want);
    srs_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= ev.mode;
    seq_kind <= ev.kind;
    update_item <= ev.item;
    set_value <= ev.value;
    rx_id <= ev.rid;
    rx_length <= ev.rlen;
    rx_byte0 <= ev.b0;
    rx_byte1 <= ev.b1;
    rx_byte2 <= ev.b2;
    do @(posedge clk); while (!in_ready);
    predicted = seq_step(ev);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait for every owed result, plus the output register's latency
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHANNEL)
      cfg_chan = data[0];
    else
      cfg_tmo = data;
  endtask

  // Mostly well-formed sequences; the rest is noise, spoiled replies and busy triggers
  task automatic run_setting(input logic chan, input logic [15:0] tmo);
    seq_event_t ev;
    seq_event_t trig;
    int         roll;
    write_reg(CFG_CHANNEL, {15'd0, chan});
    write_reg(CFG_TIMEOUT, tmo);
    for (int n = 0; n < RAND_PER_SETTING; n++) begin
      if (n == RAND_PER_SETTING / 2) quiesce();
      roll = $urandom_range(99);
      trig = mk_trigger($urandom_range(3),
                        ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(15, 9),
                        $urandom);
      if (seq_st.phase == P_IDLE) begin
        ev = (roll < 75) ? trig : rand_event();
      end else if (roll < 35) begin
        ev = mk_poll();
      end else if (roll < 70) begin
        ev = good_reply();
      end else if (roll < 80) begin
        ev = mk_tick();
      end else if (roll < 92) begin
        ev = good_reply();
        case ($urandom_range(3))
          0: ev.rid = ev.rid ^ (11'd1 << $urandom_range(10));
          1: ev.rlen = 4'($urandom_range(7));
          2: ev.b1 = ev.b1 ^ 8'($urandom_range(255, 1));
          default: ev.b0 = ev.b0 ^ 8'($urandom_range(255, 1));
        endcase
      end else begin
        ev = trig;
      end
      push_event(ev, 1'b0, '0);
    end
  endtask

  initial begin : watchdog
    for (int unsigned cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    seq_st = '0;
    seq_st.update_value = 8'hFF;
    cfg_chan = 1'b0;
    cfg_tmo = TIMEOUT_RESET;

    // Reset defaults: main channel, 500 ms timeout
    script.push_back('{mk_poll(), 1'b1, pinned(0, 0, 0, 0, 0, 0, 0, 32'(P_IDLE))});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h02, 'h50, 'hC0), 1'b1,
                       pinned(0, 0, 0, 0, 0, 0, 0, 32'(P_IDLE))});
    script.push_back('{mk_trigger(32'(KIND_INIT), 0, 'h00), 1'b1,
                       pinned(1, 0, 0, 0, 0, 0, 0, 32'(P_ENTER))});
    // busy: trigger is dropped
    script.push_back('{mk_trigger(32'(KIND_RESET), 15, 'hFF), 1'b1,
                       pinned(0, 0, 0, 0, 0, 0, 0, 32'(P_ENTER))});
    script.push_back('{mk_poll(), 1'b1,
                       pinned(0, 1, 32'(ID_E), 'h02, 'h10, 'hC0, 'hFF, 32'(P_ENTER))});
    script.push_back('{mk_poll(), 1'b1, pinned(0, 0, 0, 0, 0, 0, 0, 32'(P_ENTER))});
    script.push_back('{mk_frame(32'(RSP_ID_E), 7, 'h02, 'h50, 'hC0), 1'b1,
                       pinned(0, 0, 0, 0, 0, 0, 0, 32'(P_ENTER))});
    script.push_back('{mk_frame(32'(RSP_ID_E), 15, 'h02, 'h50, 'hC0), 1'b1,
                       pinned(1, 0, 0, 0, 0, 0, 0, 32'(P_INIT00))});
    script.push_back('{mk_frame('h7FF, 8, 'hFF, 'hFF, 'hFF), 1'b1,
                       pinned(0, 0, 0, 0, 0, 0, 0, 32'(P_INIT00))});
    script.push_back('{mk_frame(0, 0, 0, 0, 0), 1'b1,
                       pinned(0, 0, 0, 0, 0, 0, 0, 32'(P_INIT00))});
    script.push_back('{mk_poll(), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h06, 'h7B, 'h00), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h06, 'h7B, 'h20), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h06, 'h7B, 'h40), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h06, 'h7B, 'h60), 1'b0, '0});
    script.push_back('{mk_poll(), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h02, 'h50, 'h81), 1'b0, '0});
    // update with an out-of-range setting index: lands on the last setting phase
    script.push_back('{mk_trigger(32'(KIND_UPDATE), 15, 'hFF), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h02, 'h50, 'hC0), 1'b0, '0});
    script.push_back('{mk_poll(), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h02, 'h7B, 'h01), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 'h10, 'hFF, 'h00), 1'b0, '0});
    script.push_back('{mk_poll(), 1'b0, '0});
    // two consecutive frames in reverse order
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 32'(CONSEC_B), 'h00, 'h00), 1'b0, '0});
    script.push_back('{mk_frame(32'(RSP_ID_E), 8, 32'(CONSEC_A), 'h00, 'h00), 1'b0, '0});
    script.push_back('{mk_tick(), 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) push_event(script[i].ev, script[i].typed, script[i].want);

    run_setting(1'b0, TIMEOUT_RESET);
    run_setting(1'b1, ELAPSED_MAX);
    send_idle_pct = 82;
    recv_idle_pct = 20;
    run_setting(1'b0, 16'd1);
    run_setting(1'b1, 16'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_setting(1'b0, 16'd20);
    run_setting(1'b1, 16'd300);

    // Run the millisecond count past a short timeout, then poll idle and restart
    write_reg(CFG_TIMEOUT, 16'd3);
    repeat (5) push_event(mk_tick(), 1'b0, '0);
    push_event(mk_poll(), 1'b0, '0);
    push_event(mk_poll(), 1'b0, '0);
    push_event(mk_trigger(32'(KIND_RETRIEVE), 0, 0), 1'b0, '0);
    push_event(mk_poll(), 1'b0, '0);
    quiesce();

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
